@@ rtl/mta_pkg.sv @@
// Shared types, widths and codes for the mosaic tile address map.
// Used by every module of the block; depends on nothing.
package mta_pkg;

    // Field widths
    localparam int CX_W   = 21;  // canvas column
    localparam int CY_W   = 29;  // canvas row
    localparam int CHN_W  = 2;   // color channel code
    localparam int TW_W   = 13;  // tile width / height register
    localparam int LW_W   = 8;   // grid line width
    localparam int NX_W   = 9;   // tile columns
    localparam int NF_W   = 16;  // frame count
    localparam int COL_W  = 48;  // packed color
    localparam int FR_W   = 16;  // fill fraction, one channel
    localparam int SRC_W  = 12;  // source coordinate
    localparam int PX_W   = 13;  // tile pitch, tile size plus line width
    localparam int CW_W   = 22;  // canvas width
    localparam int CH_W   = 29;  // canvas height
    localparam int XQ_W   = 9;   // tile column of a pixel inside the canvas
    localparam int YQ_W   = 16;  // tile row of a pixel inside the canvas
    localparam int IDX_W  = 25;  // row * columns + column
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // Register limits
    localparam int MAX_TILE_DIM = 4096;
    localparam int MAX_FRAMES   = 65536;
    localparam int MAX_TILES    = 256;

    // Register map, one 64-bit word each
    typedef enum logic [2:0] {
        REG_TILE_WIDTH,
        REG_TILE_HEIGHT,
        REG_LINE_WIDTH,
        REG_TILES_ACROSS,
        REG_FRAME_COUNT,
        REG_GRID_COLOR,
        REG_BACK_COLOR,
        REG_NONE
    } reg_idx_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SOURCE,
        KIND_GRID,
        KIND_EMPTY,
        KIND_OUTSIDE
    } kind_t;

    // Channel codes
    localparam logic [CHN_W-1:0] CHAN_RED   = 2'd0;
    localparam logic [CHN_W-1:0] CHAN_GREEN = 2'd1;
    localparam logic [CHN_W-1:0] CHAN_BLUE  = 2'd2;

    // Settings derived from the registers
    typedef struct packed {
        logic [LW_W-1:0]  lw;
        logic [NX_W-1:0]  nx;
        logic [NF_W-1:0]  nf;
        logic [PX_W-1:0]  px;
        logic [PX_W-1:0]  py;
        logic [CW_W-1:0]  cw;
        logic [CH_W-1:0]  ch;
        logic [COL_W-1:0] grid_color;
        logic [COL_W-1:0] back_color;
    } cfg_t;

    // One request between front and back
    typedef struct packed {
        logic [CX_W-1:0]  x;
        logic [CY_W-1:0]  y;
        logic [CHN_W-1:0] chan;
        logic             outside;
    } req_t;

endpackage

@@ rtl/mta_cfg.sv @@
// Configuration registers with APB access, plus a sequencer that derives
// tile pitch, rows and canvas size after each mapped write. Depends on mta_pkg.
module mta_cfg
    import mta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg,
    output logic              cfg_busy
);

    localparam int DIV_STEPS = NF_W + 1;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL
    } state_t;

    reg_idx_t wr_idx;
    logic     wr_en;
    logic     wr_hit;

    logic [TW_W-1:0]  tw_raw_reg;
    logic [TW_W-1:0]  th_raw_reg;
    logic [LW_W-1:0]  lw_raw_reg;
    logic [NX_W-1:0]  nx_raw_reg;
    logic [NF_W-1:0]  nf_raw_reg;
    logic [COL_W-1:0] grid_reg;
    logic [COL_W-1:0] back_reg;

    logic [TW_W-1:0] tw_c;
    logic [TW_W-1:0] th_c;
    logic [NX_W-1:0] nx_c;
    logic [NF_W-1:0] nf_c;

    state_t            state_reg;
    logic [LW_W-1:0]   lw_reg;
    logic [NX_W-1:0]   nx_reg;
    logic [NF_W-1:0]   nf_reg;
    logic [PX_W-1:0]   px_reg;
    logic [PX_W-1:0]   py_reg;
    logic [CW_W-1:0]   cw_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [NX_W-1:0]   div_rem_reg;
    logic [NF_W:0]     div_num_reg;
    logic [DIV_CW-1:0] div_cnt_reg;

    logic [NX_W:0]   rem_shift;
    logic            rem_ge;
    logic [NX_W:0]   rem_sub;

    // Decode the write strobe
    assign wr_idx = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite;
    assign wr_hit = wr_en && (wr_idx != REG_NONE);

    // Hold the raw register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_raw_reg <= TW_W'(1);
            th_raw_reg <= TW_W'(1);
            lw_raw_reg <= '0;
            nx_raw_reg <= NX_W'(1);
            nf_raw_reg <= NF_W'(1);
            grid_reg   <= '0;
            back_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_TILE_WIDTH:   tw_raw_reg <= pwdata[TW_W-1:0];
                REG_TILE_HEIGHT:  th_raw_reg <= pwdata[TW_W-1:0];
                REG_LINE_WIDTH:   lw_raw_reg <= pwdata[LW_W-1:0];
                REG_TILES_ACROSS: nx_raw_reg <= pwdata[NX_W-1:0];
                REG_FRAME_COUNT:  nf_raw_reg <= pwdata[NF_W-1:0];
                REG_GRID_COLOR:   grid_reg   <= pwdata[COL_W-1:0];
                REG_BACK_COLOR:   back_reg   <= pwdata[COL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Return the raw value on reads
    always_comb
    begin
        case (wr_idx)
            REG_TILE_WIDTH:   prdata = APB_DW'(tw_raw_reg);
            REG_TILE_HEIGHT:  prdata = APB_DW'(th_raw_reg);
            REG_LINE_WIDTH:   prdata = APB_DW'(lw_raw_reg);
            REG_TILES_ACROSS: prdata = APB_DW'(nx_raw_reg);
            REG_FRAME_COUNT:  prdata = APB_DW'(nf_raw_reg);
            REG_GRID_COLOR:   prdata = APB_DW'(grid_reg);
            REG_BACK_COLOR:   prdata = APB_DW'(back_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamp: zero counts as one, large values saturate
    assign tw_c = (tw_raw_reg == '0) ? TW_W'(1) :
                  (tw_raw_reg > TW_W'(MAX_TILE_DIM)) ? TW_W'(MAX_TILE_DIM) : tw_raw_reg;
    assign th_c = (th_raw_reg == '0) ? TW_W'(1) :
                  (th_raw_reg > TW_W'(MAX_TILE_DIM)) ? TW_W'(MAX_TILE_DIM) : th_raw_reg;
    assign nx_c = (nx_raw_reg == '0) ? NX_W'(1) :
                  (nx_raw_reg > NX_W'(MAX_TILES)) ? NX_W'(MAX_TILES) : nx_raw_reg;
    // The frame limit lies above the 16-bit register range at the default size
    assign nf_c = (nf_raw_reg == '0) ? NF_W'(1) :
                  ((NF_W+1)'(nf_raw_reg) > (NF_W+1)'(MAX_FRAMES)) ?
                  NF_W'(MAX_FRAMES) : nf_raw_reg;

    // One restoring division step for tile rows = ceil(frames / columns)
    assign rem_shift = {div_rem_reg, div_num_reg[NF_W]};
    assign rem_ge    = rem_shift >= {1'b0, nx_reg};
    assign rem_sub   = rem_shift - {1'b0, nx_reg};

    // Sequence the derived settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lw_reg      <= '0;
            nx_reg      <= NX_W'(1);
            nf_reg      <= NF_W'(1);
            px_reg      <= PX_W'(1);
            py_reg      <= PX_W'(1);
            cw_reg      <= CW_W'(1);
            ch_reg      <= CH_W'(1);
            div_rem_reg <= '0;
            div_num_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (wr_hit)
        begin
            state_reg <= ST_PREP;
        end
        else
        begin
            case (state_reg)
                ST_IDLE: ;
                ST_PREP:
                begin
                    lw_reg      <= lw_raw_reg;
                    nx_reg      <= nx_c;
                    nf_reg      <= nf_c;
                    px_reg      <= tw_c + PX_W'(lw_raw_reg);
                    py_reg      <= th_c + PX_W'(lw_raw_reg);
                    div_rem_reg <= '0;
                    div_num_reg <= (NF_W+1)'(nf_c) + (NF_W+1)'(nx_c) - (NF_W+1)'(1);
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_rem_reg <= rem_ge ? rem_sub[NX_W-1:0] : rem_shift[NX_W-1:0];
                    div_num_reg <= {div_num_reg[NF_W-1:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + DIV_CW'(1);
                    if (div_cnt_reg == DIV_CW'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    cw_reg    <= CW_W'(lw_reg) + CW_W'(px_reg) * CW_W'(nx_reg);
                    ch_reg    <= CH_W'(lw_reg) + CH_W'(py_reg) * CH_W'(div_num_reg[NF_W-1:0]);
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_busy = (state_reg != ST_IDLE);

    assign cfg.lw         = lw_reg;
    assign cfg.nx         = nx_reg;
    assign cfg.nf         = nf_reg;
    assign cfg.px         = px_reg;
    assign cfg.py         = py_reg;
    assign cfg.cw         = cw_reg;
    assign cfg.ch         = ch_reg;
    assign cfg.grid_color = grid_reg;
    assign cfg.back_color = back_reg;

endmodule

@@ rtl/mta_front.sv @@
// Front end: takes start requests, flags coordinates outside the canvas
// and hands requests to the queue. Depends on mta_pkg.
module mta_front
    import mta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CX_W-1:0]  canvas_x,
    input  logic [CY_W-1:0]  canvas_y,
    input  logic [CHN_W-1:0] channel,
    input  cfg_t             cfg,
    input  logic             cfg_busy,
    input  logic             q_full,
    output logic             push,
    output req_t             push_req,
    output logic             busy
);

    logic f_valid_reg;
    logic f_valid_next;
    req_t f_req_reg;
    logic accept;

    // Stall only while settings settle or the queue cannot take the held request
    assign busy         = cfg_busy || (f_valid_reg && q_full);
    assign accept       = start && !busy;
    assign push         = f_valid_reg && !q_full;
    assign f_valid_next = accept || (f_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    // Classify on entry: outside the canvas or not
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_req_reg.x       <= canvas_x;
            f_req_reg.y       <= canvas_y;
            f_req_reg.chan    <= channel;
            f_req_reg.outside <= (CW_W'(canvas_x) >= cfg.cw) || (canvas_y >= cfg.ch);
        end
    end

    assign push_req = f_req_reg;

endmodule

@@ rtl/mta_queue.sv @@
// Two-entry request queue between front and back end.
// Depends on mta_pkg for the request type.
module mta_queue
    import mta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    input  logic pop,
    output logic head_valid,
    output req_t head_req,
    output logic full
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    req_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == (PTR_W+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ rtl/mta_back.sv @@
// Back end: pipelined division of the coordinates by the tile pitch, frame
// index and result assembly. Depends on mta_pkg.
module mta_back
    import mta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  req_t              in_req,
    input  cfg_t              cfg,
    output logic              pop,
    output logic              done,
    output logic [1:0]        kind,
    output logic [NF_W-1:0]   frame_index,
    output logic [SRC_W-1:0]  source_x,
    output logic [SRC_W-1:0]  source_y,
    output logic [FR_W-1:0]   fill_value
);

    localparam int NSTG = YQ_W;

    typedef struct packed {
        logic [CX_W-1:0]  x_rem;
        logic [XQ_W-1:0]  x_quo;
        logic [CY_W-1:0]  y_rem;
        logic [YQ_W-1:0]  y_quo;
        logic [CHN_W-1:0] chan;
        logic             outside;
    } div_t;

    div_t d_in   [NSTG];
    div_t d_out  [NSTG];
    div_t d_reg  [NSTG];
    logic v_reg  [NSTG];

    logic [PX_W-1:0]  rx;
    logic [PX_W-1:0]  ry;
    logic             m_valid_reg;
    logic             m_grid_reg;
    logic             m_outside_reg;
    logic [CHN_W-1:0] m_chan_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic [SRC_W-1:0] m_sx_reg;
    logic [SRC_W-1:0] m_sy_reg;

    logic             done_reg;
    kind_t            kind_reg;
    logic [NF_W-1:0]  frame_reg;
    logic [SRC_W-1:0] sx_reg;
    logic [SRC_W-1:0] sy_reg;
    logic [FR_W-1:0]  fill_reg;

    kind_t            kind_next;
    logic [NF_W-1:0]  frame_next;
    logic [SRC_W-1:0] sx_next;
    logic [SRC_W-1:0] sy_next;
    logic [FR_W-1:0]  fill_next;
    logic             m_empty;

    function automatic logic [FR_W-1:0] pick_channel(input logic [COL_W-1:0] color,
                                                     input logic [CHN_W-1:0] chan);
        logic [FR_W-1:0] v;
        case (chan)
            CHAN_RED:   v = color[FR_W-1:0];
            CHAN_GREEN: v = color[2*FR_W-1:FR_W];
            CHAN_BLUE:  v = color[3*FR_W-1:2*FR_W];
            default:    v = '0;
        endcase
        return v;
    endfunction

    // The back end never stalls
    assign pop = in_valid;

    // One quotient bit per stage; the column needs fewer bits than the row
    for (genvar s = 0; s < NSTG; s++)
    begin : g_div
        localparam int KY = YQ_W - 1 - s;
        logic [CY_W:0] y_sh;
        logic          y_ge;
        logic [CY_W:0] y_dif;

        if (s > 0)
        begin : g_link
            assign d_in[s] = d_reg[s-1];
        end
        else
        begin : g_seed
            // Seed the divider from the queue head
            assign d_in[s] = '{x_rem: in_req.x, x_quo: '0, y_rem: in_req.y, y_quo: '0,
                               chan: in_req.chan, outside: in_req.outside};
        end

        assign y_sh = (CY_W+1)'(cfg.py) << KY;
        assign y_ge = {1'b0, d_in[s].y_rem} >= y_sh;

        if (s < XQ_W)
        begin : g_xbit
            localparam int KX = XQ_W - 1 - s;
            logic [CX_W:0] x_sh;
            logic          x_ge;
            logic [CX_W:0] x_dif;
            assign x_sh  = (CX_W+1)'(cfg.px) << KX;
            assign x_ge  = {1'b0, d_in[s].x_rem} >= x_sh;
            assign x_dif = {1'b0, d_in[s].x_rem} - x_sh;
            assign d_out[s].x_rem = x_ge ? x_dif[CX_W-1:0] : d_in[s].x_rem;
            assign d_out[s].x_quo = {d_in[s].x_quo[XQ_W-2:0], x_ge};
        end
        else
        begin : g_xhold
            assign d_out[s].x_rem = d_in[s].x_rem;
            assign d_out[s].x_quo = d_in[s].x_quo;
        end

        assign y_dif            = {1'b0, d_in[s].y_rem} - y_sh;
        assign d_out[s].y_rem   = y_ge ? y_dif[CY_W-1:0] : d_in[s].y_rem;
        assign d_out[s].y_quo   = {d_in[s].y_quo[YQ_W-2:0], y_ge};
        assign d_out[s].chan    = d_in[s].chan;
        assign d_out[s].outside = d_in[s].outside;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[s] <= d_out[s];
        end
    end

    // Grid test, source offsets and frame index
    assign rx = d_reg[NSTG-1].x_rem[PX_W-1:0];
    assign ry = d_reg[NSTG-1].y_rem[PX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= v_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        m_grid_reg    <= (rx < PX_W'(cfg.lw)) || (ry < PX_W'(cfg.lw));
        m_outside_reg <= d_reg[NSTG-1].outside;
        m_chan_reg    <= d_reg[NSTG-1].chan;
        m_idx_reg     <= IDX_W'(d_reg[NSTG-1].y_quo) * IDX_W'(cfg.nx)
                         + IDX_W'(d_reg[NSTG-1].x_quo);
        m_sx_reg      <= SRC_W'(rx - PX_W'(cfg.lw));
        m_sy_reg      <= SRC_W'(ry - PX_W'(cfg.lw));
    end

    // Assemble the result
    assign m_empty = (m_idx_reg >= IDX_W'(cfg.nf));

    always_comb
    begin
        kind_next  = KIND_SOURCE;
        frame_next = '0;
        sx_next    = '0;
        sy_next    = '0;
        fill_next  = '0;
        if (m_outside_reg)
        begin
            kind_next = KIND_OUTSIDE;
        end
        else if (m_grid_reg)
        begin
            kind_next = KIND_GRID;
            fill_next = pick_channel(cfg.grid_color, m_chan_reg);
        end
        else if (m_empty)
        begin
            kind_next = KIND_EMPTY;
            fill_next = pick_channel(cfg.back_color, m_chan_reg);
        end
        else
        begin
            frame_next = m_idx_reg[NF_W-1:0];
            sx_next    = m_sx_reg;
            sy_next    = m_sy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        frame_reg <= frame_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        fill_reg  <= fill_next;
    end

    assign done        = done_reg;
    assign kind        = kind_reg;
    assign frame_index = frame_reg;
    assign source_x    = sx_reg;
    assign source_y    = sy_reg;
    assign fill_value  = fill_reg;

endmodule

@@ rtl/mosaic_tile_address_map.sv @@
// Top level of the mosaic tile address map: APB settings, front end,
// request queue and back end. Depends on mta_pkg and the mta_* modules.
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  -------------------------------------
//  request   start accepted when busy low   canvas_x, canvas_y, channel
//  result    done, one cycle, no stall      kind, frame_index, source_x/y, fill
//  settings  APB write, pready always high  paddr 8*i, pwdata / prdata 64 bits
//
// One request per clock while busy is low; a result passes the front register,
// the queue, the 16-stage division of the row by the tile pitch and the output
// registers. After each mapped settings write, busy stays high while the
// sequencer derives tile rows (17 division steps) and the canvas size.
// Reset is asynchronous, active low, and loads the register defaults.
// The receiver cannot hold results off; busy only reflects the settings
// sequencer and a full queue.
module mosaic_tile_address_map
    import mta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [CX_W-1:0]   canvas_x,
    input  logic [CY_W-1:0]   canvas_y,
    input  logic [CHN_W-1:0]  channel,
    output logic              done,
    output logic [1:0]        kind,
    output logic [NF_W-1:0]   frame_index,
    output logic [SRC_W-1:0]  source_x,
    output logic [SRC_W-1:0]  source_y,
    output logic [FR_W-1:0]   fill_value
);

    localparam int LATENCY = YQ_W + 4;

    cfg_t cfg;
    logic cfg_busy;
    logic q_full;
    logic push;
    req_t push_req;
    logic pop;
    logic head_valid;
    req_t head_req;

    assign pready = 1'b1;

    mta_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg      (cfg),
        .cfg_busy (cfg_busy)
    );

    mta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .canvas_x (canvas_x),
        .canvas_y (canvas_y),
        .channel  (channel),
        .cfg      (cfg),
        .cfg_busy (cfg_busy),
        .q_full   (q_full),
        .push     (push),
        .push_req (push_req),
        .busy     (busy)
    );

    mta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (push_req),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req),
        .full       (q_full)
    );

    mta_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (head_valid),
        .in_req      (head_req),
        .cfg         (cfg),
        .pop         (pop),
        .done        (done),
        .kind        (kind),
        .frame_index (frame_index),
        .source_x    (source_x),
        .source_y    (source_y),
        .fill_value  (fill_value)
    );

    // Every taken request comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request result missing at fixed latency");

    // A settings write blocks requests while derived values settle
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[5:3] != REG_NONE)) |=> busy)
        else $error("request taken while settings settle");

    // Only source pixels carry a frame and coordinates
    a_src_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind != KIND_SOURCE)) |->
        (frame_index == '0 && source_x == '0 && source_y == '0))
        else $error("frame fields set on a non-source result");

    // Outside and source results carry no fill
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind == KIND_OUTSIDE || kind == KIND_SOURCE)) |-> (fill_value == '0))
        else $error("fill value set on outside or source result");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for mosaic_tile_address_map: APB settings, pixel requests, result checks.
// Depends on mta_pkg and the RTL top level; the expected results come from a predictor kept here.
module tb
    import mta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CHN_W-1:0] CHAN_UNUSED = 2'd3;
    localparam int RESULT_LATENCY = 20;
    localparam int CYCLE_LIMIT    = 200000;

    // Expected mapping of one pixel request
    typedef struct {
        kind_t             kind;
        logic [NF_W-1:0]   frame;
        logic [SRC_W-1:0]  sx;
        logic [SRC_W-1:0]  sy;
        logic [FR_W-1:0]   fill;
    } pixel_map_t;

    // Layout derived from the settings, zero and oversized values already clamped
    typedef struct {
        longint unsigned tw, th, lw, nx, nf, px, py, cw, ch;
    } layout_geom_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic [CX_W-1:0]   canvas_x;
    logic [CY_W-1:0]   canvas_y;
    logic [CHN_W-1:0]  channel;
    logic              done;
    logic [1:0]        kind;
    logic [NF_W-1:0]   frame_index;
    logic [SRC_W-1:0]  source_x;
    logic [SRC_W-1:0]  source_y;
    logic [FR_W-1:0]   fill_value;

    // Settings as the block holds them
    logic [TW_W-1:0]  tile_w_set;
    logic [TW_W-1:0]  tile_h_set;
    logic [LW_W-1:0]  line_w_set;
    logic [NX_W-1:0]  tiles_across_set;
    logic [NF_W-1:0]  frame_count_set;
    logic [COL_W-1:0] grid_color_set;
    logic [COL_W-1:0] back_color_set;

    pixel_map_t pending_maps[$];
    int         mismatch_count = 0;
    int         results_checked = 0;
    int         layouts_programmed = 0;
    int         kind_tally[4] = '{0, 0, 0, 0};
    int         cycle_count = 0;

    mosaic_tile_address_map u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .canvas_x    (canvas_x),
        .canvas_y    (canvas_y),
        .channel     (channel),
        .done        (done),
        .kind        (kind),
        .frame_index (frame_index),
        .source_x    (source_x),
        .source_y    (source_y),
        .fill_value  (fill_value)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_maps.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint unsigned clamp_count(input longint unsigned v,
                                                    input longint unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic layout_geom_t layout_geometry();
        layout_geom_t g;
        longint unsigned ny;
        g.tw = clamp_count(tile_w_set, MAX_TILE_DIM);
        g.th = clamp_count(tile_h_set, MAX_TILE_DIM);
        g.lw = line_w_set;
        g.nx = clamp_count(tiles_across_set, MAX_TILES);
        g.nf = clamp_count(frame_count_set, MAX_FRAMES);
        ny   = (g.nf + g.nx - 1) / g.nx;
        g.px = g.tw + g.lw;
        g.py = g.th + g.lw;
        g.cw = g.lw + g.px * g.nx;
        g.ch = g.lw + g.py * ny;
        return g;
    endfunction

    function automatic logic [FR_W-1:0] channel_fraction(input logic [COL_W-1:0] color,
                                                         input logic [CHN_W-1:0] chan);
        case (chan)
            CHAN_RED:   return color[15:0];
            CHAN_GREEN: return color[31:16];
            CHAN_BLUE:  return color[47:32];
            default:    return '0;
        endcase
    endfunction

    // Predict the mapping of one canvas pixel under the current settings
    function automatic pixel_map_t map_pixel(input logic [CX_W-1:0] x,
                                             input logic [CY_W-1:0] y,
                                             input logic [CHN_W-1:0] chan);
        layout_geom_t    g;
        longint unsigned rx, ry, idx;
        pixel_map_t      m;
        g = layout_geometry();
        m.kind  = KIND_OUTSIDE;
        m.frame = '0;
        m.sx    = '0;
        m.sy    = '0;
        m.fill  = '0;
        if (x < g.cw && y < g.ch)
        begin
            rx = x % g.px;
            ry = y % g.py;
            if (rx < g.lw || ry < g.lw)
            begin
                m.kind = KIND_GRID;
                m.fill = channel_fraction(grid_color_set, chan);
            end
            else
            begin
                idx = (y / g.py) * g.nx + x / g.px;
                if (idx >= g.nf)
                begin
                    m.kind = KIND_EMPTY;
                    m.fill = channel_fraction(back_color_set, chan);
                end
                else
                begin
                    m.kind  = KIND_SOURCE;
                    m.frame = idx[NF_W-1:0];
                    m.sx    = SRC_W'(rx - g.lw);
                    m.sy    = SRC_W'(ry - g.lw);
                end
            end
        end
        return m;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR: result %0d %s got 0x%0h want 0x%0h at cycle %0d",
                 results_checked, field, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Compare each result with the oldest outstanding request
    always @(posedge clk)
    begin : check_results
        pixel_map_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_maps.size() == 0)
            begin
                report_mismatch("unrequested result, kind", kind, 0);
            end
            else
            begin
                want = pending_maps.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (frame_index !== want.frame)
                    report_mismatch("frame_index", frame_index, want.frame);
                if (source_x !== want.sx)
                    report_mismatch("source_x", source_x, want.sx);
                if (source_y !== want.sy)
                    report_mismatch("source_y", source_y, want.sy);
                if (fill_value !== want.fill)
                    report_mismatch("fill_value", fill_value, want.fill);
                kind_tally[want.kind]++;
            end
            results_checked++;
        end
    end

    // APB write: setup, access, then back to idle
    task automatic write_setting(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TILE_WIDTH:   tile_w_set       = value[TW_W-1:0];
            REG_TILE_HEIGHT:  tile_h_set       = value[TW_W-1:0];
            REG_LINE_WIDTH:   line_w_set       = value[LW_W-1:0];
            REG_TILES_ACROSS: tiles_across_set = value[NX_W-1:0];
            REG_FRAME_COUNT:  frame_count_set  = value[NF_W-1:0];
            REG_GRID_COLOR:   grid_color_set   = value[COL_W-1:0];
            REG_BACK_COLOR:   back_color_set   = value[COL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_layout(input logic [APB_DW-1:0] tw, input logic [APB_DW-1:0] th,
                                  input logic [APB_DW-1:0] lw, input logic [APB_DW-1:0] nx,
                                  input logic [APB_DW-1:0] nf, input logic [APB_DW-1:0] gc,
                                  input logic [APB_DW-1:0] bc);
        write_setting(REG_TILE_WIDTH, tw);
        write_setting(REG_TILE_HEIGHT, th);
        write_setting(REG_LINE_WIDTH, lw);
        write_setting(REG_TILES_ACROSS, nx);
        write_setting(REG_FRAME_COUNT, nf);
        write_setting(REG_GRID_COLOR, gc);
        write_setting(REG_BACK_COLOR, bc);
        layouts_programmed++;
    endtask

    // Send one pixel request; hold start high unless an idle gap follows
    task automatic issue_pixel(input logic [CX_W-1:0] x, input logic [CY_W-1:0] y,
                               input logic [CHN_W-1:0] chan, input int idle_pct);
        int gap;
        gap = 0;
        canvas_x <= x;
        canvas_y <= y;
        channel  <= chan;
        start    <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        pending_maps.push_back(map_pixel(x, y, chan));
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every outstanding result, then let the pipeline settle
    task automatic settle_results();
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [APB_DW-1:0] add_junk(input logic [APB_DW-1:0] value,
                                                   input int width);
        if ($urandom_range(3, 0) == 0)
            return value | ({$urandom, $urandom} << width);
        return value;
    endfunction

    task automatic program_random_layout();
        logic [APB_DW-1:0] tw, th, lw, nx, nf;
        case ($urandom_range(9, 0))
            0:       tw = 0;
            1:       tw = $urandom_range(8191, 4096);
            2:       tw = MAX_TILE_DIM;
            default: tw = $urandom_range(24, 1);
        endcase
        case ($urandom_range(9, 0))
            0:       th = 0;
            1:       th = $urandom_range(8191, 4096);
            2:       th = MAX_TILE_DIM;
            default: th = $urandom_range(24, 1);
        endcase
        case ($urandom_range(6, 0))
            0, 1:    lw = 0;
            2:       lw = $urandom_range(255, 0);
            default: lw = $urandom_range(4, 1);
        endcase
        case ($urandom_range(7, 0))
            0:       nx = 0;
            1:       nx = $urandom_range(511, 256);
            2:       nx = $urandom_range(511, 1);
            default: nx = $urandom_range(6, 1);
        endcase
        case ($urandom_range(7, 0))
            0:       nf = 0;
            1:       nf = $urandom_range(65535, 0);
            2:       nf = 65535;
            default: nf = $urandom_range(30, 1);
        endcase
        program_layout(add_junk(tw, TW_W), add_junk(th, TW_W), add_junk(lw, LW_W),
                       add_junk(nx, NX_W), add_junk(nf, NF_W),
                       add_junk({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF, COL_W),
                       add_junk({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF, COL_W));
        // An unmapped register must not disturb the layout
        if ($urandom_range(1, 0) == 0)
            write_setting(REG_NONE, {$urandom, $urandom});
    endtask

    // Pick a pixel biased toward the canvas, its edges and its last tile row
    task automatic issue_random_pixel(input int idle_pct);
        layout_geom_t    g;
        longint unsigned x, y;
        g = layout_geometry();
        case ($urandom_range(19, 0))
            0, 1:
            begin
                x = CX_W'($urandom);
                y = CY_W'($urandom);
            end
            2:
            begin
                x = g.cw - 1 + $urandom_range(2, 0);
                y = $urandom_range(32'(g.ch - 1), 0);
            end
            3:
            begin
                x = $urandom_range(32'(g.cw - 1), 0);
                y = g.ch - 1 + $urandom_range(2, 0);
            end
            4, 5, 6:
            begin
                x = $urandom_range(32'(g.cw - 1), 0);
                y = $urandom_range(32'(g.ch - 1), 32'(g.ch - g.py));
            end
            default:
            begin
                x = $urandom_range(32'(g.cw - 1), 0);
                y = $urandom_range(32'(g.ch - 1), 0);
            end
        endcase
        issue_pixel(x, y, $urandom_range(3, 0), idle_pct);
    endtask

    // Defaults give a one-pixel canvas
    task automatic test_reset_defaults();
        issue_pixel(0, 0, CHAN_RED, 0);
        issue_pixel(1, 0, CHAN_GREEN, 0);
        issue_pixel(0, 1, CHAN_BLUE, 0);
        end_burst();
        settle_results();
    endtask

    // 3x2 tiles, 2-pixel lines, 3 columns, 4 frames: grid, empty, source, outside
    task automatic test_small_grid();
        program_layout(3, 2, 2, 3, 4, 64'h3333_2222_1111, 64'h6666_5555_4444);
        write_setting(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_pixel(0, 0, CHAN_RED, 0);
        issue_pixel(1, 5, CHAN_GREEN, 0);
        issue_pixel(16, 9, CHAN_UNUSED, 0);
        issue_pixel(2, 2, CHAN_BLUE, 0);
        issue_pixel(4, 7, CHAN_RED, 0);
        issue_pixel(12, 6, CHAN_RED, 0);
        issue_pixel(12, 6, CHAN_GREEN, 0);
        issue_pixel(12, 6, CHAN_BLUE, 0);
        issue_pixel(12, 6, CHAN_UNUSED, 0);
        issue_pixel(17, 0, CHAN_RED, 0);
        issue_pixel(0, 10, CHAN_GREEN, 0);
        issue_pixel({CX_W{1'b1}}, {CY_W{1'b1}}, CHAN_BLUE, 0);
        end_burst();
        settle_results();
    endtask

    // Zero sizes and counts act as one
    task automatic test_zero_settings();
        program_layout(64'hFFFF_0000_0000_0000, 0, 0, 0, 64'hA5A5_0000_0000_0000,
                       64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF);
        issue_pixel(0, 0, CHAN_GREEN, 0);
        issue_pixel(1, 0, CHAN_RED, 0);
        end_burst();
        settle_results();
    endtask

    // Oversized tile sizes and columns saturate; largest frame count
    task automatic test_oversized_settings();
        layout_geom_t g;
        program_layout(8191, 8191, 255, 511, 65535, 64'h8000_7FFF_0001, 64'hFFFF_0000_FFFF);
        g = layout_geometry();
        issue_pixel(g.cw - 256, g.ch - 256, CHAN_BLUE, 0);
        issue_pixel(g.cw - 256 - g.px, g.ch - 256, CHAN_RED, 0);
        issue_pixel(g.cw - 1, g.ch - 1, CHAN_GREEN, 0);
        issue_pixel(g.cw, 0, CHAN_RED, 0);
        issue_pixel(0, g.ch, CHAN_RED, 0);
        end_burst();
        settle_results();
    endtask

    // Stop sending until the pipeline is empty, then resume
    task automatic test_pause_until_drained();
        program_random_layout();
        repeat (30) issue_random_pixel(0);
        end_burst();
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (30) issue_random_pixel(0);
        end_burst();
        settle_results();
    endtask

    // Random layouts under several sender idle rates
    task automatic test_random_layouts();
        int idle_plan[7];
        idle_plan = '{0, 50, 6, 0, 50, 6, 0};
        foreach (idle_plan[p])
        begin
            program_random_layout();
            repeat (200) issue_random_pixel(idle_plan[p]);
            end_burst();
            settle_results();
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        start    <= 1'b0;
        canvas_x <= '0;
        canvas_y <= '0;
        channel  <= CHAN_RED;
        tile_w_set       = 1;
        tile_h_set       = 1;
        line_w_set       = 0;
        tiles_across_set = 1;
        frame_count_set  = 1;
        grid_color_set   = '0;
        back_color_set   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_small_grid();
        test_zero_settings();
        test_oversized_settings();
        test_pause_until_drained();
        test_random_layouts();

        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 5) @(posedge clk);

        $display("Checked %0d pixel results over %0d layouts, %0d mismatches",
                 results_checked, layouts_programmed, mismatch_count);
        $display("Kinds seen: %0d source, %0d grid, %0d empty tile, %0d outside",
                 kind_tally[KIND_SOURCE], kind_tally[KIND_GRID],
                 kind_tally[KIND_EMPTY], kind_tally[KIND_OUTSIDE]);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
